### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL, empty when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked property, muted while reset is low.
`define KMGS_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("kmgs: assertion failed");
// Invariant that must hold at every clocked edge out of reset.
`define KMGS_ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("kmgs: invariant broken");
`else
`define KMGS_ASSERT(name, prop)
`define KMGS_ASSERT_ALWAYS(name, expr)
`endif
`endif

### rtl/core/kmgs_pkg.sv
// Types, constants and helpers for the key matrix ghost scanner.
package kmgs_pkg;

    localparam logic [7:0] JOY_IDLE     = 8'h1F;
    localparam logic [7:0] GATE_OPEN    = 8'h80;
    localparam logic [7:0] PORT_IDLE    = 8'hFF;
    localparam logic [7:0] CODE_SKIP    = 8'h21;
    localparam logic [7:0] CODE_RELEASE = 8'h2F;
    localparam int unsigned MAX_ROUNDS  = 17;
    localparam int unsigned POSITIONS   = 64;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_POLL = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PORT   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_SEARCH = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    // One spreading round: next row/column masks and whether nothing changed.
    typedef struct packed {
        logic [7:0] rows;
        logic [7:0] cols;
        logic       stable;
    } spread_t;

    // Result word, last field in the lowest bits.
    typedef struct packed {
        logic [6:0] pad;
        logic       idle_reset;
        logic       event_new;
        logic [7:0] event_code;
        logic [5:0] key_position;
        logic       key_found;
        logic       scan_ran;
        logic       joystick_gated;
        logic       joy_moved;
        logic [4:0] joystick_bits;
        logic [7:0] port_b_value;
    } result_t;

    function automatic result_t kmgs_result(
        input logic [7:0] pb,
        input logic [7:0] gate,
        input logic       scanned,
        input logic       found,
        input logic [5:0] pos,
        input logic [7:0] ev,
        input logic       fresh
    );
        result_t r;
        logic    active;
        logic    gated;
        active = (pb[4:0] != JOY_IDLE[4:0]);
        gated  = (gate != GATE_OPEN);
        r.pad              = '0;
        r.port_b_value     = pb;
        r.joystick_bits    = gated ? JOY_IDLE[4:0] : pb[4:0];
        r.joy_moved        = active;
        r.joystick_gated   = gated;
        r.scan_ran         = scanned;
        r.key_found        = found;
        r.key_position     = pos;
        r.event_code       = ev;
        r.event_new        = fresh;
        r.idle_reset       = active | fresh;
        return r;
    endfunction

endpackage

### rtl/core/kmgs_ram.sv
// Generic single-port-write, registered-read RAM.
module kmgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/kmgs_spread.sv
// One round of low-level spreading through closed switches of the matrix.
module kmgs_spread
    import kmgs_pkg::*;
(
    input  logic [63:0] keys,
    input  logic [7:0]  rows,
    input  logic [7:0]  cols,
    output spread_t     nxt
);

    logic [7:0] nr;
    logic [7:0] nc;

    always_comb
    begin
        nr = rows;
        nc = cols;
        for (int i = 0; i < 8; i++)
        begin
            // a low column pulls every row it touches low, and vice versa
            if (cols[i])
            begin
                nr = nr | keys[i*8 +: 8];
            end
            if (|(rows & keys[i*8 +: 8]))
            begin
                nc[i] = 1'b1;
            end
        end
        nxt.rows   = nr;
        nxt.cols   = nc;
        nxt.stable = (nr == rows) && (nc == cols);
    end

endmodule

### rtl/core/keyboard_matrix_ghost_scanner.sv
// Top level: sequencer around the shared spreading unit and the code table.
//
//  channel | dir | handshake              | content
//  s_*     | in  | s_tvalid / s_tready    | tuser action, tdata load or poll word
//  m_*     | out | m_tvalid / m_tready    | tdata result word, one per poll
//
// A load gives no word. A poll runs the port closure in 1..17 spreading rounds; with a
// busy port the result then goes out from the output state. With both ports idle the
// port closure settles in one round, then 8 row closures of 1..17 rounds each and a walk
// of the 64-entry table (one read a cycle) precede the output state. Reset is
// asynchronous and leaves the table undefined. While a result waits on m_tready the next
// poll holds in its output state and no input word is taken.
`include "assert_macros.svh"
module keyboard_matrix_ghost_scanner
    import kmgs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // table_index[5:0] table_value[13:6] key_matrix[77:14]
    // port_a_lines[85:78] port_b_lines[93:86] gate_value[101:94], zero pad
    input  logic [103:0] s_tdata,
    // action[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // port_b_value[7:0] joystick_bits[12:8] joy_moved[13]
    // joystick_gated[14] scan_ran[15] key_found[16]
    // key_position[22:17] event_code[30:23] event_new[31] idle_reset[32], pad
    output logic [39:0]  m_tdata
);

    state_t      state_reg, state_next;
    logic [63:0] keys_reg, keys_next;
    logic [7:0]  pa_reg, pa_next;
    logic [7:0]  gate_reg, gate_next;
    logic [7:0]  pb_reg, pb_next;
    logic [7:0]  rows_reg, rows_next;
    logic [7:0]  cols_reg, cols_next;
    logic [4:0]  round_reg, round_next;
    logic [2:0]  row_reg, row_next;
    logic [63:0] reach_reg, reach_next;
    logic [6:0]  addr_reg, addr_next;
    logic        chk_valid_reg, chk_valid_next;
    logic [5:0]  chk_pos_reg, chk_pos_next;
    logic [7:0]  held_reg, held_next;
    logic [7:0]  event_reg, event_next;
    result_t     res_reg, res_next;
    logic        m_tvalid_reg, m_tvalid_next;
    result_t     m_tdata_reg, m_tdata_next;

    spread_t     spr;
    logic        closure_done;
    logic [7:0]  closure_cols;
    logic [7:0]  pb_w;
    logic [7:0]  code_w;
    logic        load_w;
    logic        poll_w;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign load_w   = s_tvalid && s_tready && (s_tuser == ACT_LOAD);
    assign poll_w   = s_tvalid && s_tready && (s_tuser == ACT_POLL);

    kmgs_spread u_spread (
        .keys (keys_reg),
        .rows (rows_reg),
        .cols (cols_reg),
        .nxt  (spr)
    );

    kmgs_ram #(
        .WIDTH (8),
        .DEPTH (POSITIONS)
    ) u_table (
        .clk   (clk),
        .we    (load_w),
        .waddr (s_tdata[5:0]),
        .wdata (s_tdata[13:6]),
        .raddr (addr_reg[5:0]),
        .rdata (code_w)
    );

    // closure ends when a round changes nothing or the round budget runs out
    assign closure_done = spr.stable || (round_reg == 5'(MAX_ROUNDS - 1));
    assign closure_cols = spr.stable ? cols_reg : spr.cols;
    assign pb_w         = ~closure_cols;

    always_comb
    begin
        state_next     = state_reg;
        keys_next      = keys_reg;
        pa_next        = pa_reg;
        gate_next      = gate_reg;
        pb_next        = pb_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        round_next     = round_reg;
        row_next       = row_reg;
        reach_next     = reach_reg;
        addr_next      = addr_reg;
        chk_valid_next = chk_valid_reg;
        chk_pos_next   = chk_pos_reg;
        held_next      = held_reg;
        event_next     = event_reg;
        res_next       = res_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (poll_w)
                begin
                    keys_next  = s_tdata[77:14];
                    pa_next    = s_tdata[85:78];
                    gate_next  = s_tdata[101:94];
                    rows_next  = ~s_tdata[85:78];
                    cols_next  = ~s_tdata[93:86];
                    round_next = '0;
                    state_next = S_PORT;
                end
            end
            S_PORT:
            begin
                if (closure_done)
                begin
                    pb_next = pb_w;
                    if (pa_reg == PORT_IDLE && pb_w == PORT_IDLE)
                    begin
                        rows_next  = 8'd1;
                        cols_next  = '0;
                        round_next = '0;
                        row_next   = '0;
                        reach_next = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        res_next   = kmgs_result(pb_w, gate_reg, 1'b0, 1'b0, 6'd0,
                                                 event_reg, 1'b0);
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    rows_next  = spr.rows;
                    cols_next  = spr.cols;
                    round_next = round_reg + 5'd1;
                end
            end
            S_SCAN:
            begin
                if (closure_done)
                begin
                    // position p = column*8 + row
                    for (int p = 0; p < 64; p++)
                    begin
                        if (3'(p) == row_reg)
                        begin
                            reach_next[p] = closure_cols[p / 8];
                        end
                    end
                    round_next = '0;
                    cols_next  = '0;
                    if (row_reg == 3'd7)
                    begin
                        addr_next      = '0;
                        chk_valid_next = 1'b0;
                        state_next     = S_SEARCH;
                    end
                    else
                    begin
                        row_next  = row_reg + 3'd1;
                        rows_next = 8'd1 << (row_reg + 3'd1);
                    end
                end
                else
                begin
                    rows_next  = spr.rows;
                    cols_next  = spr.cols;
                    round_next = round_reg + 5'd1;
                end
            end
            S_SEARCH:
            begin
                // the registered table read returns in the cycle after its address
                if (addr_reg != 7'(POSITIONS))
                begin
                    chk_valid_next = 1'b1;
                    chk_pos_next   = addr_reg[5:0];
                    addr_next      = addr_reg + 7'd1;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end

                if (chk_valid_reg && reach_reg[chk_pos_reg] && code_w != CODE_SKIP)
                begin
                    if (code_w != held_reg)
                    begin
                        if (code_w == CODE_RELEASE)
                        begin
                            held_next = '0;
                            res_next  = kmgs_result(pb_reg, gate_reg, 1'b1, 1'b1,
                                                    chk_pos_reg, event_reg, 1'b0);
                        end
                        else
                        begin
                            held_next  = code_w;
                            event_next = code_w;
                            res_next   = kmgs_result(pb_reg, gate_reg, 1'b1, 1'b1,
                                                     chk_pos_reg, code_w, 1'b1);
                        end
                    end
                    else
                    begin
                        res_next = kmgs_result(pb_reg, gate_reg, 1'b1, 1'b1,
                                               chk_pos_reg, event_reg, 1'b0);
                    end
                    state_next = S_OUT;
                end
                else if (!chk_valid_reg && addr_reg == 7'(POSITIONS))
                begin
                    held_next  = '0;
                    res_next   = kmgs_result(pb_reg, gate_reg, 1'b1, 1'b0, 6'd0,
                                             event_reg, 1'b0);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            round_reg     <= '0;
            row_reg       <= '0;
            addr_reg      <= '0;
            chk_valid_reg <= 1'b0;
            held_reg      <= '0;
            event_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            row_reg       <= row_next;
            addr_reg      <= addr_next;
            chk_valid_reg <= chk_valid_next;
            held_reg      <= held_next;
            event_reg     <= event_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        keys_reg    <= keys_next;
        pa_reg      <= pa_next;
        gate_reg    <= gate_next;
        pb_reg      <= pb_next;
        rows_reg    <= rows_next;
        cols_reg    <= cols_next;
        reach_reg   <= reach_next;
        chk_pos_reg <= chk_pos_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    `KMGS_ASSERT_ALWAYS(a_held_never_release, held_reg != CODE_RELEASE)
    `KMGS_ASSERT(a_poll_starts_closure, poll_w |=> state_reg == S_PORT)
    `KMGS_ASSERT(a_new_needs_hit, m_tvalid_reg && m_tdata_reg.event_new |-> m_tdata_reg.key_found)
    `KMGS_ASSERT(a_round_bound, (state_reg == S_PORT || state_reg == S_SCAN) |-> round_reg < 5'(MAX_ROUNDS))

endmodule

### sim/testbench.sv
// Self-checking testbench for the key matrix ghost scanner.
`timescale 1ns / 1ps

module testbench;
    import kmgs_pkg::*;

    typedef struct {
        logic        action;
        logic [5:0]  idx;
        logic [7:0]  code;
        logic [63:0] keys;
        logic [7:0]  pa;
        logic [7:0]  pb;
        logic [7:0]  gate;
    } scan_item_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // table_index, table_value, key_matrix, port_a_lines, port_b_lines, gate_value, pad
    logic [103:0] s_tdata = '0;
    // action
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // port_b_value, joystick_bits, joy_moved, joystick_gated, scan_ran,
    // key_found, key_position, event_code, event_new, idle_reset, pad
    logic [39:0]  m_tdata;

    keyboard_matrix_ghost_scanner dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    scan_item_t pending_items[$];
    result_t    poll_results_due[$];
    scan_item_t item_on_bus;

    // predictor state
    logic [7:0] code_table [64];
    logic [7:0] held_code = 8'h00;
    logic [7:0] event_byte = 8'h00;
    logic [7:0] last_pos;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;
    int words_seen = 0;
    int loads_done = 0;
    int polls_done = 0;
    int scans_done = 0;
    int keys_found = 0;
    int events_done = 0;
    int gated_done = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 100)
            $display("ERROR @%0t word %0d: %s", $time, words_seen, msg);
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // Columns left low once the low rows/columns have spread through closed keys.
    function automatic logic [7:0] spread_cols(input logic [63:0] keys,
                                               input logic [7:0] rows,
                                               input logic [7:0] cols);
        logic [7:0] nr;
        logic [7:0] nc;
        logic [7:0] colbits;
        for (int round = 0; round < MAX_ROUNDS; round++)
        begin
            nr = rows;
            nc = cols;
            for (int i = 0; i < 8; i++)
            begin
                colbits = keys[i*8 +: 8];
                if (cols[i])
                    nr = nr | colbits;
                if ((rows & colbits) != 8'h00)
                    nc[i] = 1'b1;
            end
            if (nr == rows && nc == cols)
                break;
            rows = nr;
            cols = nc;
        end
        return cols;
    endfunction

    task automatic compute_poll_result(input scan_item_t it);
        result_t    r;
        logic [7:0] pbv;
        logic [7:0] reach [8];
        logic [7:0] hit_code;
        logic       fresh;
        fresh = 1'b0;
        pbv = ~spread_cols(it.keys, ~it.pa, ~it.pb);
        r = '0;
        r.port_b_value    = pbv;
        r.joy_moved       = (pbv[4:0] != JOY_IDLE[4:0]);
        r.joystick_gated  = (it.gate != GATE_OPEN);
        r.joystick_bits   = r.joystick_gated ? JOY_IDLE[4:0] : pbv[4:0];
        if (it.pa == PORT_IDLE && pbv == PORT_IDLE)
        begin
            r.scan_ran = 1'b1;
            for (int row = 0; row < 8; row++)
                reach[row] = spread_cols(it.keys, 8'h01 << row, 8'h00);
            last_pos = 8'hFF;
            for (int p = 0; p < POSITIONS; p++)
            begin
                if (reach[p % 8][p / 8] && code_table[p] != CODE_SKIP)
                begin
                    last_pos = 8'(p);
                    break;
                end
            end
            if (last_pos == 8'hFF)
                held_code = 8'h00;
            else
            begin
                hit_code = code_table[last_pos[5:0]];
                r.key_found    = 1'b1;
                r.key_position = last_pos[5:0];
                if (hit_code != held_code)
                begin
                    if (hit_code == CODE_RELEASE)
                        held_code = 8'h00;
                    else
                    begin
                        event_byte = hit_code;
                        held_code  = hit_code;
                        fresh      = 1'b1;
                    end
                end
            end
        end
        r.event_code = event_byte;
        r.event_new  = fresh;
        r.idle_reset = r.joy_moved | fresh;
        scans_done  += r.scan_ran;
        keys_found  += r.key_found;
        events_done += fresh;
        gated_done  += r.joystick_gated;
        polls_done++;
        poll_results_due.push_back(r);
    endtask

    // driver: keeps a word on the bus until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (item_on_bus.action == ACT_LOAD)
                begin
                    code_table[item_on_bus.idx] = item_on_bus.code;
                    loads_done++;
                end
                else
                    compute_poll_result(item_on_bus);
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item_on_bus = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= item_on_bus.action;
                    s_tdata  <= {2'b00, item_on_bus.gate, item_on_bus.pb, item_on_bus.pa,
                                 item_on_bus.keys, item_on_bus.code, item_on_bus.idx};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                words_seen++;
                got = result_t'(m_tdata);
                if (poll_results_due.size() == 0)
                    report_error("result word with no poll outstanding");
                else
                begin
                    want = poll_results_due.pop_front();
                    compare_field("port_b_value", got.port_b_value, want.port_b_value);
                    compare_field("joystick_bits", got.joystick_bits, want.joystick_bits);
                    compare_field("joy_moved", got.joy_moved, want.joy_moved);
                    compare_field("joystick_gated", got.joystick_gated, want.joystick_gated);
                    compare_field("scan_ran", got.scan_ran, want.scan_ran);
                    compare_field("key_found", got.key_found, want.key_found);
                    compare_field("key_position", got.key_position, want.key_position);
                    compare_field("event_code", got.event_code, want.event_code);
                    compare_field("event_new", got.event_new, want.event_new);
                    compare_field("idle_reset", got.idle_reset, want.idle_reset);
                    compare_field("pad", got.pad, want.pad);
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // skip and release codes come up often so those paths get exercised
    function automatic logic [7:0] biased_code();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            return CODE_SKIP;
        if (pick < 35)
            return CODE_RELEASE;
        return 8'($urandom);
    endfunction

    function automatic logic [63:0] pick_keys();
        logic [63:0] keys;
        int          pick;
        int          n;
        keys = '0;
        pick = $urandom_range(99);
        if (pick < 15)
            n = 0;
        else if (pick < 50)
            n = 1;
        else if (pick < 80)
            n = $urandom_range(2, 4);
        else if (pick < 90)
            n = $urandom_range(8, 16);
        else
            return {$urandom, $urandom};
        for (int k = 0; k < n; k++)
            keys[$urandom_range(63)] = 1'b1;
        return keys;
    endfunction

    task automatic push_load(input logic [5:0] idx, input logic [7:0] code);
        scan_item_t it;
        it.action = ACT_LOAD;
        it.idx    = idx;
        it.code   = code;
        it.keys   = {$urandom, $urandom};
        it.pa     = 8'($urandom);
        it.pb     = 8'($urandom);
        it.gate   = 8'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic push_poll(input logic [63:0] keys, input logic [7:0] pa,
                             input logic [7:0] pb, input logic [7:0] gate);
        scan_item_t it;
        it.action = ACT_POLL;
        it.idx    = 6'($urandom);
        it.code   = 8'($urandom);
        it.keys   = keys;
        it.pa     = pa;
        it.pb     = pb;
        it.gate   = gate;
        pending_items.push_back(it);
    endtask

    task automatic push_random_poll(input logic [63:0] keys, input logic ports_idle);
        logic [7:0] pa;
        logic [7:0] pb;
        logic [7:0] gate;
        pa = PORT_IDLE;
        pb = PORT_IDLE;
        if (!ports_idle)
        begin
            case ($urandom_range(3))
                0: pa = 8'($urandom);
                1: pb = 8'($urandom);
                2:
                begin
                    pa = 8'($urandom);
                    pb = 8'($urandom);
                end
                default: pa = ~(8'h01 << $urandom_range(7));
            endcase
        end
        gate = ($urandom_range(1) == 1) ? GATE_OPEN : 8'($urandom);
        push_poll(keys, pa, pb, gate);
    endtask

    // press / hold / release bursts, with table rewrites sprinkled in
    task automatic queue_random(input int n);
        int          count;
        int          reps;
        logic [63:0] keys;
        count = 0;
        while (count < n)
        begin
            if ($urandom_range(99) < 8)
            begin
                push_load(6'($urandom), biased_code());
                count++;
            end
            keys = pick_keys();
            reps = $urandom_range(1, 4);
            for (int k = 0; k < reps; k++)
            begin
                push_random_poll(keys, $urandom_range(99) < 80);
                count++;
            end
            if ($urandom_range(1) == 1)
            begin
                push_random_poll(64'h0, 1'b1);
                count++;
            end
        end
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || poll_results_due.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // whole table first so a scan never reads an unwritten entry
        for (int i = 0; i < POSITIONS; i++)
            push_load(6'(i), biased_code());

        push_load(6'd5, 8'h41);
        push_load(6'd6, CODE_RELEASE);
        push_load(6'd7, CODE_SKIP);
        push_load(6'd0, 8'h30);
        push_load(6'd63, 8'hFF);
        push_load(6'd12, 8'h00);
        push_poll(64'h0, PORT_IDLE, PORT_IDLE, GATE_OPEN);              // nothing pressed
        push_poll(64'h1 << 5, PORT_IDLE, PORT_IDLE, GATE_OPEN);         // new event
        push_poll(64'h1 << 5, PORT_IDLE, PORT_IDLE, GATE_OPEN);         // held, same code
        push_poll(64'h1 << 6, PORT_IDLE, PORT_IDLE, GATE_OPEN);         // release code
        push_poll(64'h1 << 6, PORT_IDLE, PORT_IDLE, GATE_OPEN);
        push_poll((64'h1 << 7) | (64'h1 << 12), PORT_IDLE, PORT_IDLE, GATE_OPEN); // skip
        push_poll(64'h1 << 63, PORT_IDLE, PORT_IDLE, GATE_OPEN);
        push_poll(64'h302, PORT_IDLE, PORT_IDLE, GATE_OPEN);            // ghost at position 0
        push_poll('1, PORT_IDLE, PORT_IDLE, 8'hFF);
        push_poll('1, 8'h00, PORT_IDLE, 8'h00);
        push_poll(64'h0, PORT_IDLE, 8'h00, 8'h7F);
        push_poll(64'h1, 8'hFE, PORT_IDLE, GATE_OPEN);
        push_poll(64'h301, 8'hFD, PORT_IDLE, GATE_OPEN);                // ghost on a port read
        push_poll(64'h1 << 63, 8'h7F, PORT_IDLE, 8'h81);
        push_poll(64'h0, 8'h00, PORT_IDLE, GATE_OPEN);
        queue_random(305);
        drain();

        send_idle_pct = 76;
        queue_random(305);
        drain();

        send_idle_pct = 0;
        stall_pct = 76;
        queue_random(305);
        drain();

        send_idle_pct = 21;
        stall_pct = 21;
        queue_random(305);
        drain();

        repeat (250) @(posedge clk);
        if (poll_results_due.size() != 0)
            report_error("polls left without a result word");
        $display("Ran %0d table loads and %0d polls: %0d scans, %0d keys found, %0d new events,",
                 loads_done, polls_done, scans_done, keys_found, events_done);
        $display("%0d gated joystick reads, over phases without and with sender and sink idling.",
                 gated_done);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

### keyboard_matrix_ghost_scanner.f
+incdir+rtl/core
rtl/core/kmgs_pkg.sv
rtl/core/kmgs_ram.sv
rtl/core/kmgs_spread.sv
rtl/core/keyboard_matrix_ghost_scanner.sv
sim/testbench.sv
